@@ hw/rtl/crpt_pkg.sv @@
// Shared types and constants for the convex region point test.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package crpt_pkg;

    localparam int COORD_W      = 16;
    localparam int COUNT_W      = 16;
    localparam int PLANE_W      = 64;
    localparam int PLANE_REGS   = 7;
    localparam int MAX_PLANES_DEF = 7;
    localparam int NUM_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int Q_SHIFT      = 14;
    localparam int PROD_W       = 2 * COORD_W;
    // three products plus the scaled offset: two guard bits over a product
    localparam int SUM_W        = PROD_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PLANES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_0    = 3'd1;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    // One point travelling down the chain of plane cells.
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      first;
        logic                      in_hull;
    } pt_t;

endpackage

`default_nettype wire

@@ hw/rtl/crpt_cell.sv @@
// One plane cell: tests the passing point against a single plane in two stages.
// Depends on crpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crpt_cell #(
    parameter int INDEX = 0
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 adv,
    input  wire  [crpt_pkg::NUM_W-1:0]          num_planes,
    input  wire  [crpt_pkg::PLANE_W-1:0]        plane,
    input  wire  crpt_pkg::pt_t                 pt_in,
    output crpt_pkg::pt_t                       pt_out
);

    localparam logic [crpt_pkg::NUM_W-1:0] IDX = crpt_pkg::NUM_W'(INDEX);

    // stage A: products
    crpt_pkg::pt_t                              pt_a_reg;
    logic                                       en_a_reg;
    logic signed [crpt_pkg::PROD_W-1:0]         pa_reg, pb_reg, pc_reg;
    logic signed [crpt_pkg::COORD_W-1:0]        d_reg;

    // stage B: sum and sign
    crpt_pkg::pt_t                              pt_b_reg;

    logic signed [crpt_pkg::COORD_W-1:0]        coef_a, coef_b, coef_c;
    logic signed [crpt_pkg::SUM_W-1:0]          sum;
    logic                                       pass;

    assign coef_a = plane[15:0];
    assign coef_b = plane[31:16];
    assign coef_c = plane[47:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_a_reg.valid <= 1'b0;
            pt_b_reg.valid <= 1'b0;
        end else if (adv) begin
            pt_a_reg.valid <= pt_in.valid;
            pt_b_reg.valid <= pt_a_reg.valid;
        end
        if (adv) begin
            pt_a_reg.x       <= pt_in.x;
            pt_a_reg.y       <= pt_in.y;
            pt_a_reg.z       <= pt_in.z;
            pt_a_reg.first   <= pt_in.first;
            pt_a_reg.in_hull <= pt_in.in_hull;
            en_a_reg         <= (num_planes > IDX);
            pa_reg           <= coef_a * pt_in.x;
            pb_reg           <= coef_b * pt_in.y;
            pc_reg           <= coef_c * pt_in.z;
            d_reg            <= plane[63:48];

            pt_b_reg.x       <= pt_a_reg.x;
            pt_b_reg.y       <= pt_a_reg.y;
            pt_b_reg.z       <= pt_a_reg.z;
            pt_b_reg.first   <= pt_a_reg.first;
            pt_b_reg.in_hull <= pt_a_reg.in_hull & (~en_a_reg | pass);
        end
    end

    always_comb begin
        sum = crpt_pkg::SUM_W'(pa_reg) + crpt_pkg::SUM_W'(pb_reg) + crpt_pkg::SUM_W'(pc_reg)
            + {{(crpt_pkg::SUM_W - crpt_pkg::COORD_W - crpt_pkg::Q_SHIFT){d_reg[15]}},
               d_reg, {crpt_pkg::Q_SHIFT{1'b0}}};
        // a sum of exactly zero lies on the plane and counts as inside
        pass = sum[crpt_pkg::SUM_W-1] | (sum == '0);
    end

    assign pt_out = pt_b_reg;

endmodule

`default_nettype wire

@@ hw/rtl/crpt_run.sv @@
// Leading-count tracker and output register at the end of the plane chain.
// Depends on crpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crpt_run (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            adv,
    input  wire  crpt_pkg::pt_t            pt_in,
    output logic                           out_valid,
    output logic                           out_inside,
    output logic [crpt_pkg::COUNT_W-1:0]   out_count
);

    logic                          run_alive_reg, run_alive_next;
    logic [crpt_pkg::COUNT_W-1:0]  run_count_reg, run_count_next;
    logic                          valid_reg;
    logic                          inside_reg;

    always_comb begin
        run_alive_next = run_alive_reg;
        run_count_next = run_count_reg;
        if (pt_in.first) begin
            run_alive_next = 1'b1;
            run_count_next = '0;
        end
        if (run_alive_next) begin
            if (pt_in.in_hull) begin
                if (run_count_next != crpt_pkg::COUNT_LIMIT)
                    run_count_next = run_count_next + 1'b1;
            end else begin
                run_alive_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_alive_reg <= 1'b1;
            run_count_reg <= '0;
            valid_reg     <= 1'b0;
        end else if (adv) begin
            valid_reg <= pt_in.valid;
            if (pt_in.valid) begin
                run_alive_reg <= run_alive_next;
                run_count_reg <= run_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv)
            inside_reg <= pt_in.in_hull;
    end

    assign out_valid  = valid_reg;
    assign out_inside = inside_reg;
    assign out_count  = run_count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/convex_region_point_test_unit.sv @@
// Pipeline: two stages per plane cell (products, then sum and sign), then one
// output register, from input transaction to m_axis_tvalid.
// Throughput: one point per cycle; the whole chain advances together whenever
// the output register is empty or being taken, so s_axis_tready follows that.
// Reset (aresetn, synchronous, active low): no planes active, plane registers
// zero, pipeline empty, leading count zero with counting active.
`timescale 1ns / 1ps
`default_nettype none

module convex_region_point_test_unit #(
    parameter int MAX_PLANES = crpt_pkg::MAX_PLANES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // point_x[15:0], point_y[31:16], point_z[47:32]
    input  wire  [0:0]  s_axis_tuser,   // first_point[0]

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // inside_res[0], leading_count[16:1], zero[23:17]

    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [crpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [crpt_pkg::PLANE_W-1:0]      cfg_data
);

    logic [crpt_pkg::NUM_W-1:0]   num_planes_reg;
    logic [crpt_pkg::PLANE_W-1:0] plane_reg [MAX_PLANES];

    crpt_pkg::pt_t                link [MAX_PLANES+1];
    logic                         adv;
    logic                         out_inside;
    logic [crpt_pkg::COUNT_W-1:0] out_count;

    assign cfg_ready = 1'b1;

    // plane registers past MAX_PLANES have no storage; writes there are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_planes_reg <= '0;
            for (int i = 0; i < MAX_PLANES; i++)
                plane_reg[i] <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == crpt_pkg::REG_NUM_PLANES)
                num_planes_reg <= cfg_data[crpt_pkg::NUM_W-1:0];
            for (int i = 0; i < MAX_PLANES; i++)
                if (cfg_index == crpt_pkg::REG_PLANE_0 + crpt_pkg::CFG_IDX_W'(i))
                    plane_reg[i] <= cfg_data;
        end
    end

    assign adv           = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = adv;

    always_comb begin
        link[0].valid   = s_axis_tvalid;
        link[0].x       = s_axis_tdata[15:0];
        link[0].y       = s_axis_tdata[31:16];
        link[0].z       = s_axis_tdata[47:32];
        link[0].first   = s_axis_tuser[0];
        link[0].in_hull = 1'b1;
    end

    for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
        crpt_cell #(
            .INDEX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .num_planes (num_planes_reg),
            .plane      (plane_reg[g]),
            .pt_in      (link[g]),
            .pt_out     (link[g+1])
        );
    end

    crpt_run u_run (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .pt_in      (link[MAX_PLANES]),
        .out_valid  (m_axis_tvalid),
        .out_inside (out_inside),
        .out_count  (out_count)
    );

    assign m_axis_tdata = {7'b0, out_count, out_inside};

endmodule

`default_nettype wire

@@ test/tb_convex_region_point_test_unit.sv @@
// Self-checking testbench for convex_region_point_test_unit: directed table, a short
// full-speed inside run, then randomized plane sets and points.
// Depends on crpt_pkg and the unit under test; no files or arguments are read.
`timescale 1ns / 1ps

module tb_convex_region_point_test_unit;

    localparam int LATENCY       = 2 * crpt_pkg::MAX_PLANES_DEF + 1;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int BURST_RUN     = 64;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 120;
    localparam int TABLE_ROWS    = 26;

    typedef struct packed {
        logic signed [crpt_pkg::COORD_W-1:0] x;
        logic signed [crpt_pkg::COORD_W-1:0] y;
        logic signed [crpt_pkg::COORD_W-1:0] z;
        logic                                first;
    } point_t;

    typedef struct packed {
        logic                         in_hull;
        logic [crpt_pkg::COUNT_W-1:0] count;
    } verdict_t;

    typedef enum logic {ROW_POINT, ROW_REG} row_kind_e;

    // point rows carry {0, z, y, x} in data; register rows carry the write value
    typedef struct packed {
        row_kind_e                      kind;
        logic [crpt_pkg::CFG_IDX_W-1:0] idx;
        logic [crpt_pkg::PLANE_W-1:0]   data;
        logic                           first;
        logic                           typed;
        logic                           exp_inside;
        logic [crpt_pkg::COUNT_W-1:0]   exp_count;
    } dir_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [47:0]                    s_axis_tdata;
    logic [0:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [23:0]                    m_axis_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [crpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crpt_pkg::PLANE_W-1:0]   cfg_data;

    // shadow of the block's registers and run state
    logic [crpt_pkg::NUM_W-1:0]   planes_on = '0;
    logic [crpt_pkg::PLANE_W-1:0] plane_bank [crpt_pkg::PLANE_REGS] = '{default: '0};
    logic [crpt_pkg::COUNT_W-1:0] run_len = '0;
    logic                         counting = 1'b1;

    verdict_t verdict_q [$];
    int       errors = 0;
    int       cycles = 0;
    bit       full_speed = 1'b0;

    convex_region_point_test_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_convex_region_point_test_unit failed");
            $finish;
        end
    end

    // four 16-bit words, lowest first
    function automatic logic [63:0] pack4(int w0, int w1, int w2, int w3);
        return {16'(w3), 16'(w2), 16'(w1), 16'(w0)};
    endfunction

    function automatic logic plane_excludes(logic [crpt_pkg::PLANE_W-1:0] p, point_t pt);
        longint a, b, c, d, sum;
        a = $signed(p[15:0]);
        b = $signed(p[31:16]);
        c = $signed(p[47:32]);
        d = $signed(p[63:48]);
        sum = a * pt.x + b * pt.y + c * pt.z + (d <<< crpt_pkg::Q_SHIFT);
        return sum > 0;
    endfunction

    function automatic verdict_t judge_point(point_t pt);
        verdict_t v;
        logic     ins;
        ins = 1'b1;
        for (int i = 0; i < planes_on; i++)
            if (plane_excludes(plane_bank[i], pt))
                ins = 1'b0;
        if (pt.first) begin
            run_len  = '0;
            counting = 1'b1;
        end
        if (counting) begin
            if (ins) begin
                if (run_len != crpt_pkg::COUNT_LIMIT)
                    run_len++;
            end else begin
                counting = 1'b0;
            end
        end
        v.in_hull = ins;
        v.count   = run_len;
        return v;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        if (span == 0)
            return 16'($urandom());
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_point(point_t pt, logic use_typed, verdict_t typed_v);
        verdict_t v;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pt.z, pt.y, pt.x};
        s_axis_tuser  <= pt.first;
        do @(posedge aclk); while (!s_axis_tready);
        v = judge_point(pt);
        verdict_q.push_back(use_typed ? typed_v : v);
    endtask

    task automatic maybe_gap(int pct);
        int n;
        if ($urandom_range(0, 99) < pct) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            repeat (n) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [crpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [crpt_pkg::PLANE_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == crpt_pkg::REG_NUM_PLANES)
            planes_on = value[crpt_pkg::NUM_W-1:0];
        else
            plane_bank[idx - crpt_pkg::REG_PLANE_0] = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: ready bursts broken by mostly short stalls, or always ready at full speed
    initial begin
        int burst, stall;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (full_speed) begin
                @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 24);
                repeat (burst) begin
                    @(negedge aclk);
                    m_axis_tready <= 1'b1;
                end
                stall = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
                repeat (stall) begin
                    @(negedge aclk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result transaction with no point outstanding: tdata=%h", m_axis_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.in_hull) begin
                    $error("inside_res: expected %0d, got %0d", want.in_hull, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[16:1] !== want.count) begin
                    $error("leading_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[16:1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        dir_row_t                   dir_rows [TABLE_ROWS];
        point_t                     pt;
        int                         span, mode, idle_pct, dmax;
        logic [crpt_pkg::NUM_W-1:0] count_sel;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        dir_rows = '{
            // no planes after reset: everything inside, counting from reset state
            '{ROW_POINT, '0, pack4(0, 0, 0, 0), 1'b0, 1'b1, 1'b1, 16'd1},
            '{ROW_POINT, '0, pack4(32767, -32768, 32767, 0), 1'b0, 1'b1, 1'b1, 16'd2},
            '{ROW_POINT, '0, pack4(-32768, 32767, -32768, 0), 1'b1, 1'b1, 1'b1, 16'd1},
            '{ROW_POINT, '0, pack4(-1, -1, -1, 0), 1'b0, 1'b1, 1'b1, 16'd2},
            // x <= 5
            '{ROW_REG, crpt_pkg::REG_PLANE_0, pack4(16384, 0, 0, -5),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, crpt_pkg::REG_NUM_PLANES, 64'd1, 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(5, 0, 0, 0), 1'b1, 1'b1, 1'b1, 16'd1},
            '{ROW_POINT, '0, pack4(6, 0, 0, 0), 1'b0, 1'b1, 1'b0, 16'd1},
            '{ROW_POINT, '0, pack4(0, 0, 0, 0), 1'b0, 1'b1, 1'b1, 16'd1},
            '{ROW_POINT, '0, pack4(6, 0, 0, 0), 1'b1, 1'b1, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(-32768, 0, 0, 0), 1'b1, 1'b1, 1'b1, 16'd1},
            // extreme field values; planes 1 and 2 meet at x+y+z == -16384
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 1), pack4(-32768, -32768, -32768, -32768),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 2), pack4(32767, 32767, 32767, 32767),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 3), 64'd0, 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 4), pack4(0, 0, -16384, -32768),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 5), pack4(0, -16384, 0, -32768),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, 3'(crpt_pkg::REG_PLANE_0 + 6), pack4(16384, 16384, 16384, -32768),
              1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, crpt_pkg::REG_NUM_PLANES, 64'd7, 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(32767, 32767, 32767, 0), 1'b1, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(-32768, -32768, -32768, 0), 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(-16384, 0, 0, 0), 1'b1, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(-16384, 1, 0, 0), 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(0, -16384, 0, 0), 1'b1, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(1, -16383, -2, 0), 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_REG, crpt_pkg::REG_NUM_PLANES, 64'd0, 1'b0, 1'b0, 1'b0, 16'd0},
            '{ROW_POINT, '0, pack4(32767, 32767, 32767, 0), 1'b0, 1'b0, 1'b0, 16'd0}
        };

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                pt.x     = dir_rows[r].data[15:0];
                pt.y     = dir_rows[r].data[31:16];
                pt.z     = dir_rows[r].data[47:32];
                pt.first = dir_rows[r].first;
                send_point(pt, dir_rows[r].typed,
                           {dir_rows[r].exp_inside, dir_rows[r].exp_count});
                maybe_gap(30);
            end
        end

        // one unbroken inside run with the result side always ready
        drain();
        full_speed = 1'b1;
        for (int k = 0; k < BURST_RUN; k++) begin
            pt.x     = 16'($urandom());
            pt.y     = 16'($urandom());
            pt.z     = 16'($urandom());
            pt.first = (k == 0);
            send_point(pt, 1'b0, '0);
        end
        full_speed = 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            mode = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0:       span = 64;
                1:       span = 2048;
                default: span = 0;
            endcase
            dmax = (span == 0) ? 32768 : span;
            for (int p = 0; p < crpt_pkg::PLANE_REGS; p++) begin
                if (mode == 3)
                    write_reg(3'(crpt_pkg::REG_PLANE_0 + p), {$urandom(), $urandom()});
                else
                    // origin inside, normals up to 1.0, offset on the scale of the points
                    write_reg(3'(crpt_pkg::REG_PLANE_0 + p),
                              pack4(int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    -int'($urandom_range(1, dmax))));
            end
            if (ph == 0)
                count_sel = 3'd7;
            else if (ph == 1)
                count_sel = 3'd0;
            else
                count_sel = crpt_pkg::NUM_W'($urandom_range(0, 7));
            write_reg(crpt_pkg::REG_NUM_PLANES, 64'(count_sel));
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 25;
                default: idle_pct = 60;
            endcase
            repeat (PHASE_ITEMS) begin
                pt.x     = rand_coord(span);
                pt.y     = rand_coord(span);
                pt.z     = rand_coord(span);
                pt.first = ($urandom_range(0, 15) == 0);
                send_point(pt, 1'b0, '0);
                maybe_gap(idle_pct);
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0)
            $display("tb_convex_region_point_test_unit passed");
        else
            $display("tb_convex_region_point_test_unit failed");
        $finish;
    end

endmodule
